>>> sv/sfpa_pkg.sv
// ============================================================================
// sfpa_pkg: shared types and constants of the stack fixed-point ALU
// Operation and status codes, sequencer states, payload structs and the
// fixed-point scale used by the multiply and divide paths.
// ============================================================================
package sfpa_pkg;

  localparam int unsigned DATA_W              = 32;
  localparam int unsigned STACK_DEPTH_DEFAULT = 16;
  localparam int unsigned FIX_SCALE           = 1000;

  // The divider retires two quotient bits per cycle over a 64-bit dividend.
  localparam int unsigned DIV_BITS_PER_STEP = 2;
  localparam int unsigned DIV_STEPS         = 64 / DIV_BITS_PER_STEP;
  localparam int unsigned DIV_CNT_W         = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_DUP  = 3'd2,
    OP_SWAP = 3'd3,
    OP_ADD  = 3'd4,
    OP_SUB  = 3'd5,
    OP_MUL  = 3'd6,
    OP_DIV  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_OVF  = 2'd2,
    ST_DIV0 = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_DUP_WR,
    S_SWAP_WR,
    S_DIV_LOAD,
    S_DIV,
    S_DIV_DONE,
    S_RD_TOP,
    S_TOP_WAIT
  } state_e;

  typedef struct packed {
    op_e                mode;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         stack_count;
    status_e            status;
  } out_t;

endpackage

>>> sv/stack_fixed_point_alu_top.sv
// ============================================================================
// stack_fixed_point_alu_top: operand stack with a decimal fixed-point ALU
// Sequencer around a stack memory, one shared multiplier and an iterative
// radix-4 restoring divider.
// ============================================================================
// Usage:
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one stack
// operation per transfer: push, pop, dup, swap, add, sub, mul or div. Every
// accepted operation produces exactly one transfer on the output channel
// (out_valid_o/out_ready_i, out_data_o) with the new top of stack, the word
// count and a status code. Values are signed with a scale of 1000.
// Order of states: push, pop and any refused operation go straight to the
// top-of-stack read; dup first reads the top word and writes its copy;
// add, sub, swap and a divide by zero read both operands and execute, and
// swap then writes its second word; mul and div with a non-zero divisor
// pass through the shared divider over the 64-bit dividend. The block
// handles one operation at a time: in_ready_o is high only while the
// sequencer is idle, and that idle cycle can already accept the next
// operation. Reset clears the word count and the handshake state; no
// clearing pass is run, since stack words are never read before they are
// written. When the receiver stalls, the result holds in the output
// register; the sequencer may accept and work on the next operation, then
// waits before its own result until the output register is free.
// ============================================================================
module stack_fixed_point_alu_top #(
  parameter int unsigned STACK_DEPTH = sfpa_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sfpa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sfpa_pkg::out_t out_data_o
);
  import sfpa_pkg::*;

  // Address width indexes the memory; the fill count must also hold the depth.
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

  // Control state.
  state_e          state_q, state_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic            out_valid_q, out_valid_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // Payload registers.
  op_e             op_q, op_d;
  status_e         status_q, status_d;
  logic [31:0]     a_q, a_d;
  logic [31:0]     b_q, b_d;
  logic signed [63:0] prod_q, prod_d;
  logic [63:0]     dq_q, dq_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     divisor_q, divisor_d;
  logic            neg_q, neg_d;
  out_t            out_q, out_d;

  // Stack memory, one write and one registered read port.
  logic [31:0]     mem [STACK_DEPTH];
  logic [31:0]     rd_q;
  logic [AW-1:0]   raddr;
  logic            mem_we;
  logic [AW-1:0]   waddr;
  logic [31:0]     wdata;

  // Derived values.
  logic            in_fire;
  logic            out_free;
  logic            is_full;
  logic            is_empty;
  logic            below_two;
  logic [FW-1:0]   fill_m1;
  logic [FW-1:0]   fill_m2;
  logic [31:0]     mul_y;
  logic [31:0]     b_abs;
  logic [32:0]     rem_step;
  logic [63:0]     dq_step;
  logic [33:0]     trial;
  logic [31:0]     quot_lo;
  logic [31:0]     quot_res;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign is_full   = (fill_q == FW'(STACK_DEPTH));
  assign is_empty  = (fill_q == '0);
  assign below_two = (fill_q < FW'(2));
  assign fill_m1   = fill_q - FW'(1);
  assign fill_m2   = fill_q - FW'(2);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Only the second word is read from the lower slot; every other read
  // looks at the current top.
  always_comb begin
    unique case (state_q)
      S_RD_A:  raddr = fill_m2[AW-1:0];
      default: raddr = fill_m1[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Shared multiplier: a times b for mul, a times the scale for div.
  assign mul_y = (op_q == OP_MUL) ? b_q : 32'(FIX_SCALE);
  assign b_abs = b_q[31] ? (32'd0 - b_q) : b_q;

  // Two restoring division steps per cycle.
  always_comb begin
    rem_step = rem_q;
    dq_step  = dq_q;
    trial    = '0;
    for (int k = 0; k < int'(DIV_BITS_PER_STEP); k++) begin
      rem_step = {rem_step[31:0], dq_step[63]};
      dq_step  = {dq_step[62:0], 1'b0};
      trial    = {1'b0, rem_step} - {2'b00, divisor_q};
      if (!trial[33]) begin
        rem_step   = trial[32:0];
        dq_step[0] = 1'b1;
      end
    end
  end

  assign quot_lo  = dq_q[31:0];
  assign quot_res = neg_q ? (32'd0 - quot_lo) : quot_lo;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          priority case (in_data_i.mode)
            OP_PUSH, OP_POP: state_d = S_RD_TOP;
            OP_DUP:          state_d = (is_empty || is_full) ? S_RD_TOP : S_RD_B;
            default:         state_d = below_two ? S_RD_TOP : S_RD_B;
          endcase
        end
      end
      S_RD_B:     state_d = (op_q == OP_DUP) ? S_DUP_WR : S_RD_A;
      S_RD_A:     state_d = S_EXEC;
      S_EXEC: begin
        priority case (op_q)
          OP_SWAP: state_d = S_SWAP_WR;
          OP_MUL:  state_d = S_DIV_LOAD;
          OP_DIV:  state_d = (b_q == '0) ? S_RD_TOP : S_DIV_LOAD;
          default: state_d = S_RD_TOP;
        endcase
      end
      S_DUP_WR:   state_d = S_RD_TOP;
      S_SWAP_WR:  state_d = S_RD_TOP;
      S_DIV_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DIV_DONE;
        end
      end
      S_DIV_DONE: state_d = S_RD_TOP;
      S_RD_TOP:   state_d = S_TOP_WAIT;
      S_TOP_WAIT: state_d = out_free ? S_IDLE : S_TOP_WAIT;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_cnt_d   = div_cnt_q;
    op_d        = op_q;
    status_d    = status_q;
    a_d         = a_q;
    b_d         = b_q;
    prod_d      = prod_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    divisor_d   = divisor_q;
    neg_d       = neg_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    waddr       = fill_q[AW-1:0];
    wdata       = in_data_i.push_value;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d     = in_data_i.mode;
          status_d = ST_OK;
          priority case (in_data_i.mode)
            OP_PUSH: begin
              if (is_full) begin
                status_d = ST_OVF;
              end else begin
                mem_we = 1'b1;
                fill_d = fill_q + FW'(1);
              end
            end
            OP_POP: begin
              if (is_empty) begin
                status_d = ST_FEW;
              end else begin
                fill_d = fill_m1;
              end
            end
            OP_DUP: begin
              if (is_empty) begin
                status_d = ST_FEW;
              end else if (is_full) begin
                status_d = ST_OVF;
              end
            end
            default: begin
              if (below_two) begin
                status_d = ST_FEW;
              end
            end
          endcase
        end
      end
      S_RD_A: begin
        b_d = rd_q;
      end
      S_EXEC: begin
        a_d       = rd_q;
        waddr     = fill_m2[AW-1:0];
        neg_d     = rd_q[31] ^ b_q[31];
        divisor_d = (op_q == OP_MUL) ? 32'(FIX_SCALE) : b_abs;
        prod_d    = 64'($signed(rd_q)) * 64'($signed(mul_y));
        priority case (op_q)
          OP_SWAP: begin
            mem_we = 1'b1;
            wdata  = b_q;
          end
          OP_ADD: begin
            mem_we = 1'b1;
            wdata  = rd_q + b_q;
            fill_d = fill_m1;
          end
          OP_SUB: begin
            mem_we = 1'b1;
            wdata  = rd_q - b_q;
            fill_d = fill_m1;
          end
          OP_DIV: begin
            if (b_q == '0) begin
              mem_we   = 1'b1;
              wdata    = '0;
              fill_d   = fill_m1;
              status_d = ST_DIV0;
            end
          end
          default: begin
          end
        endcase
      end
      S_DUP_WR: begin
        mem_we = 1'b1;
        wdata  = rd_q;
        fill_d = fill_q + FW'(1);
      end
      S_SWAP_WR: begin
        mem_we = 1'b1;
        waddr  = fill_m1[AW-1:0];
        wdata  = a_q;
      end
      S_DIV_LOAD: begin
        dq_d      = prod_q[63] ? (64'd0 - 64'(prod_q)) : 64'(prod_q);
        rem_d     = '0;
        div_cnt_d = '0;
      end
      S_DIV: begin
        dq_d      = dq_step;
        rem_d     = rem_step;
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      end
      S_DIV_DONE: begin
        mem_we = 1'b1;
        waddr  = fill_m2[AW-1:0];
        wdata  = quot_res;
        fill_d = fill_m1;
      end
      S_TOP_WAIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.top_value   = is_empty ? '0 : rd_q;
          out_d.stack_count = 5'(fill_q);
          out_d.status      = status_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    status_q  <= status_d;
    a_q       <= a_d;
    b_q       <= b_d;
    prod_q    <= prod_d;
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    neg_q     <= neg_d;
    out_q     <= out_d;
  end

endmodule

>>> sv/sfpa_checker.sv
// ============================================================================
// sfpa_checker: port-level assertions for the stack fixed-point ALU
// Watches both channels of the top level and is attached to it by bind.
// ============================================================================
module sfpa_checker #(
  parameter int unsigned STACK_DEPTH = sfpa_pkg::STACK_DEPTH_DEFAULT
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sfpa_pkg::out_t out_data_o
);
  import sfpa_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // One operation at a time: after an input transfer the block is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted in consecutive cycles");

  // An empty stack reports a zero top word.
  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.stack_count == 5'd0) |-> (out_data_o.top_value == 32'sd0))
    else $error("empty stack with non-zero top");

  // An overflow is only reported on a full stack.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_OVF)
      |-> (out_data_o.stack_count == 5'(STACK_DEPTH)))
    else $error("overflow status on a stack that is not full");

endmodule

bind stack_fixed_point_alu_top sfpa_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sfpa_checker (.*);

>>> dv/tb_stack_fixed_point_alu_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_stack_fixed_point_alu_top: self-checking bench for the stack ALU
// Drives stack operations over the input channel, predicts every result with
// a bit-accurate model of the operand stack and the scale-1000 arithmetic,
// and compares each output transfer field by field with the oldest prediction.
// ============================================================================
module tb_stack_fixed_point_alu_top;
  import sfpa_pkg::*;

  localparam int unsigned DEPTH        = STACK_DEPTH_DEFAULT;
  localparam longint      FIX_ONE      = longint'(FIX_SCALE);
  localparam logic [31:0] WORD_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
  localparam logic [31:0] WORD_NEG_ONE = 32'hffff_ffff;
  // Cycles with no transfer on either channel before the run is abandoned.
  // This leaves a wide margin over the slowest operation, a mul or div
  // through the divider, even under heavy random stalling on both sides.
  localparam int          STALL_LIMIT  = 4000;
  // Quiet time after the last result, a little above the divide latency.
  localparam int          DRAIN_CYCLES = 60;
  localparam int          PHASE_ITEMS  = 410;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i   = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  stack_fixed_point_alu_top #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the operand stack. Only entries below model_fill are ever
  // read, matching the rule that the block never reads an unwritten word.
  logic [31:0] model_words [DEPTH];
  int          model_fill;

  // Predicted results, oldest first.
  out_t        pending_results [$];

  // Idling knobs, percent of cycles in which each side holds back.
  int          send_idle_pct;
  int          recv_stall_pct;

  int          ops_sent;
  int          results_checked;
  int          mismatches;
  int          orphan_results;
  int          quiet_cycles;
  int          op_seen     [8];
  int          status_seen [4];

  // ---------------------------------------------------------------------------
  // Clock. 20 ns period.
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Applies one operation to the shadow stack and returns the
  // result transfer that the block must produce for it. Binary operations
  // take the second word as a and the top word as b.
  // ---------------------------------------------------------------------------
  function automatic out_t apply_stack_op(in_t op);
    out_t        res;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [31:0] wr;
    longint      sa;
    longint      sb;
    longint      quo;
    res.status = ST_OK;
    wr = '0;
    case (op.mode)
      OP_PUSH: begin
        if (model_fill >= DEPTH) begin
          res.status = ST_OVF;
        end else begin
          model_words[model_fill] = op.push_value;
          model_fill++;
        end
      end
      OP_POP: begin
        if (model_fill == 0) res.status = ST_FEW;
        else model_fill--;
      end
      OP_DUP: begin
        if (model_fill == 0) begin
          res.status = ST_FEW;
        end else if (model_fill >= DEPTH) begin
          res.status = ST_OVF;
        end else begin
          model_words[model_fill] = model_words[model_fill - 1];
          model_fill++;
        end
      end
      default: begin
        if (model_fill < 2) begin
          res.status = ST_FEW;
        end else begin
          wa = model_words[model_fill - 2];
          wb = model_words[model_fill - 1];
          sa = longint'($signed(wa));
          sb = longint'($signed(wb));
          if (op.mode == OP_SWAP) begin
            model_words[model_fill - 2] = wb;
            model_words[model_fill - 1] = wa;
          end else begin
            case (op.mode)
              OP_ADD: wr = wa + wb;
              OP_SUB: wr = wa - wb;
              OP_MUL: begin
                // Full 64-bit product, truncated toward zero, low word kept.
                quo = (sa * sb) / FIX_ONE;
                wr  = quo[31:0];
              end
              default: begin
                if (sb == 0) begin
                  wr         = '0;
                  res.status = ST_DIV0;
                end else begin
                  quo = (sa * FIX_ONE) / sb;
                  wr  = quo[31:0];
                end
              end
            endcase
            model_fill--;
            model_words[model_fill - 1] = wr;
          end
        end
      end
    endcase
    res.top_value   = (model_fill != 0) ? model_words[model_fill - 1] : '0;
    res.stack_count = model_fill[4:0];
    return res;
  endfunction

  // A word for push: full-range random in four draws of ten, with plenty of
  // values near the fixed-point unit and the range limits so that mul and
  // div see both wrap and ordinary truncation.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w = $urandom;
      4, 5, 6:    w = $urandom_range(0, 400000) - 200000;
      7:          w = ($urandom_range(0, 200) - 100) * 1000;
      8: begin
        case ($urandom_range(0, 4))
          0:       w = '0;
          1:       w = WORD_MAX;
          2:       w = WORD_MIN;
          3:       w = 32'd1;
          default: w = WORD_NEG_ONE;
        endcase
      end
      default:    w = ($urandom_range(0, 1) != 0) ? 32'd1000 : -32'sd1000;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Optionally idles for a random number of cycles, then offers one
  // operation and holds it until the transfer completes. The prediction is
  // made at the accepting edge, so the shadow stack is always up to date
  // when the next operation is chosen. Valid is left high on return; the next
  // call or the caller decides whether it drops.
  // ---------------------------------------------------------------------------
  task automatic send_op(input op_e mode, input logic [31:0] value);
    in_t item;
    item.mode       = mode;
    item.push_value = value;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), apply_stack_op(item));
    op_seen[mode]++;
    ops_sent++;
  endtask

  // Holds the input channel off until every predicted result has come back.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. Ready is redrawn every cycle from the current stall rate.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Checker. Every output transfer is matched against the oldest prediction.
  // A transfer with nothing predicted counts as a failure on its own.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    logic bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        orphan_results++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected result: top=%0d count=%0d status=%s",
                   $realtime, out_data_o.top_value, out_data_o.stack_count,
                   out_data_o.status.name());
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_seen[want.status]++;
        bad = (out_data_o.top_value   !== want.top_value)   ||
              (out_data_o.stack_count !== want.stack_count) ||
              (out_data_o.status      !== want.status);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result %0d mismatch: top exp %0d got %0d, count exp %0d got %0d,",
                     $realtime, results_checked, want.top_value, out_data_o.top_value,
                     want.stack_count, out_data_o.stack_count);
            $display("    status exp %s got %s", want.status.name(),
                     out_data_o.status.name());
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog. Counts cycles in which neither channel completes a transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a transfer", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hand-picked operations: operand shortage on an empty and a one-word
  // stack, add and sub wrap, mul and div results out of 32-bit range, divide
  // by zero, truncation toward zero of negative results, and swap.
  // ---------------------------------------------------------------------------
  task automatic test_corner_ops();
    send_op(OP_POP,  '0);
    send_op(OP_DUP,  '0);
    send_op(OP_ADD,  '0);
    send_op(OP_PUSH, WORD_MAX);
    send_op(OP_SWAP, '0);
    send_op(OP_MUL,  '0);
    send_op(OP_DUP,  '0);
    send_op(OP_ADD,  '0);          // Max plus max wraps to -2.
    send_op(OP_PUSH, WORD_MIN);
    send_op(OP_SUB,  '0);          // -2 minus min wraps back positive.
    send_op(OP_PUSH, WORD_MAX);
    send_op(OP_MUL,  '0);          // Product far beyond 32 bits.
    send_op(OP_PUSH, '0);
    send_op(OP_DIV,  '0);          // Divisor zero gives a zero result.
    send_op(OP_PUSH, WORD_MIN);
    send_op(OP_PUSH, WORD_NEG_ONE);
    send_op(OP_DIV,  '0);          // Min times 1000 over -1 wraps.
    send_op(OP_PUSH, -32'sd1500);
    send_op(OP_PUSH, 32'd2333);
    send_op(OP_MUL,  '0);          // -3499.5 truncates to -3499.
    send_op(OP_PUSH, 32'd7);
    send_op(OP_PUSH, -32'sd3);
    send_op(OP_DIV,  '0);          // -2333.33 truncates to -2333.
    send_op(OP_SWAP, '0);
    send_op(OP_SUB,  '0);
  endtask

  // ---------------------------------------------------------------------------
  // Fills the stack to its depth with random words, checks that push and dup
  // on a full stack are dropped, then empties it and checks operand shortage
  // on an empty and a one-word stack.
  // ---------------------------------------------------------------------------
  task automatic test_stack_limits();
    while (model_fill < DEPTH) send_op(OP_PUSH, random_word());
    send_op(OP_PUSH, random_word());
    send_op(OP_DUP,  random_word());
    send_op(OP_ADD,  random_word());
    while (model_fill > 0) send_op(OP_POP, random_word());
    send_op(OP_POP,  random_word());
    send_op(OP_SWAP, random_word());
    send_op(OP_PUSH, random_word());
    send_op(OP_DIV,  random_word());
    send_op(OP_POP,  random_word());
  endtask

  // ---------------------------------------------------------------------------
  // Random operations. Most picks keep at least two words on the stack so
  // that the arithmetic paths see real operands; a share is pure noise, and
  // now and then the stack is driven to full or to empty and beyond.
  // ---------------------------------------------------------------------------
  task automatic test_random_mix(input int count);
    int  target;
    int  pick;
    op_e mode;
    target = ops_sent + count;
    while (ops_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        while (model_fill < DEPTH) send_op(OP_PUSH, random_word());
        send_op(OP_PUSH, random_word());
        send_op(OP_DUP,  random_word());
      end else if (pick < 6) begin
        while (model_fill > 0) send_op(OP_POP, random_word());
        send_op(op_e'($urandom_range(1, 7)), random_word());
      end else if (pick < 16) begin
        send_op(op_e'($urandom_range(0, 7)), random_word());
      end else begin
        if (model_fill < 2) begin
          mode = OP_PUSH;
        end else if (model_fill >= DEPTH - 1) begin
          mode = op_e'($urandom_range(1, 7));
        end else if ($urandom_range(0, 99) < 30) begin
          mode = OP_PUSH;
        end else begin
          mode = op_e'($urandom_range(1, 7));
        end
        // Occasionally place a zero divisor right before a divide.
        if (mode == OP_DIV && $urandom_range(0, 9) == 0) send_op(OP_PUSH, '0);
        send_op(mode, random_word());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run. Reset once, the directed checks with no idling, then
  // random phases under different idling patterns. Between phases the sender
  // holds off until every predicted result has arrived.
  // ---------------------------------------------------------------------------
  initial begin
    model_fill      = 0;
    ops_sent        = 0;
    results_checked = 0;
    mismatches      = 0;
    orphan_results  = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_ops();
    test_stack_limits();
    wait_results_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(PHASE_ITEMS);
    wait_results_drained();

    send_idle_pct  = 79;
    recv_stall_pct = 0;
    test_random_mix(PHASE_ITEMS);
    wait_results_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 79;
    test_random_mix(PHASE_ITEMS);
    wait_results_drained();

    send_idle_pct  = 36;
    recv_stall_pct = 36;
    test_random_mix(PHASE_ITEMS);
    test_stack_limits();

    // All stimulus is in; wait for the last results and a quiet tail so that
    // any stray output transfer is still caught.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d operations: push %0d pop %0d dup %0d swap %0d add %0d sub %0d",
             ops_sent, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_DUP],
             op_seen[OP_SWAP], op_seen[OP_ADD], op_seen[OP_SUB]);
    $display("  mul %0d div %0d; statuses ok %0d few %0d overflow %0d div0 %0d; %0d mismatches",
             op_seen[OP_MUL], op_seen[OP_DIV], status_seen[ST_OK], status_seen[ST_FEW],
             status_seen[ST_OVF], status_seen[ST_DIV0], mismatches);
    if (mismatches == 0 && orphan_results == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sfpa_pkg.sv
sv/stack_fixed_point_alu_top.sv
sv/sfpa_checker.sv
dv/tb_stack_fixed_point_alu_top.sv
